### design/pmt_pkg.sv
// Package for the prescaled match timer: field widths, access codes and
// register indexes. No dependencies.
package pmt_pkg;

  // Data path widths
  localparam int DataWidth     = 32;
  localparam int FlagWidth     = 4;
  localparam int ActionBits    = 3;
  localparam int CfgIndexWidth = 3;

  // Channel count range and default
  localparam int MaxMatchChannels     = 4;
  localparam int DefaultMatchChannels = 4;

  // Item kinds
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  // Bus-visible registers
  typedef enum logic [1:0] {
    SEL_FLAGS    = 2'd0,
    SEL_CONTROL  = 2'd1,
    SEL_COUNT    = 2'd2,
    SEL_PRESCALE = 2'd3
  } reg_sel_t;

  // Configuration register indexes
  localparam logic [CfgIndexWidth-1:0] CFG_PRESCALE_LIMIT = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_MATCH_A        = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_MATCH_ACTIONS  = 3'd5;

  // Control register bit positions
  localparam int CtrlEnableBit = 0;
  localparam int CtrlHoldBit   = 1;

  // Action bit positions within one channel's group
  localparam int ActFlagBit  = 0;
  localparam int ActClearBit = 1;
  localparam int ActStopBit  = 2;

endpackage

### design/prescaled_match_timer_top.sv
// Prescaled match timer: prescaler, 32-bit count, match channels, sticky flags.
// Depends on pmt_pkg.
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------
//  in      | in_valid / in_stall     | mode, reg_select, write_data
//  out     | out_valid / out_stall   | read_data, irq, match_flags, running
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One item is taken per cycle unless stalled; its result is registered in the
// output register or skid. The state update is one pass of prescale compare,
// count increment and the match compares. A skid register behind the output
// holds one word while out_stall is high; in_stall rises only while the skid
// is full. rst clears all state and configuration. cfg_ready is always high.
module prescaled_match_timer_top #(
  parameter int MATCH_CHANNELS = pmt_pkg::DefaultMatchChannels
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          mode,
  input  logic [1:0]                          reg_select,
  input  logic [pmt_pkg::DataWidth-1:0]       write_data,
  // Result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pmt_pkg::DataWidth-1:0]       read_data,
  output logic                                irq,
  output logic [pmt_pkg::FlagWidth-1:0]       match_flags,
  output logic                                running,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pmt_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [pmt_pkg::DataWidth-1:0]       cfg_data
);
  import pmt_pkg::*;

  localparam int ActWidth = ActionBits * MATCH_CHANNELS;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 irq;
    logic [FlagWidth-1:0] flags;
    logic                 running;
  } result_t;

  // Configuration registers
  logic [DataWidth-1:0] prescale_limit;
  logic [DataWidth-1:0] match_value [MATCH_CHANNELS];
  logic [ActWidth-1:0]  match_actions;

  // Timer state
  logic [DataWidth-1:0]      count_value, count_value_next;
  logic [DataWidth-1:0]      prescale_count, prescale_count_next;
  logic                      enable_bit, enable_bit_next;
  logic                      reset_hold, reset_hold_next;
  logic [MATCH_CHANNELS-1:0] flag_bits, flag_bits_next;
  logic                      clear_pending, clear_pending_next;

  // Output register and skid
  result_t out_word, skid_word, result_next;
  logic    skid_valid;
  logic    in_accept, out_take;

  logic [DataWidth-1:0]      advanced_count;
  logic [MATCH_CHANNELS-1:0] hit, set_flags;
  logic                      do_clear, do_stop;
  logic [DataWidth-1:0]      rd;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  // Take configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_limit <= '0;
      match_actions  <= '0;
      for (int ch = 0; ch < MATCH_CHANNELS; ch++) begin
        match_value[ch] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PRESCALE_LIMIT) begin
        prescale_limit <= cfg_data;
      end
      if (cfg_index == CFG_MATCH_ACTIONS) begin
        match_actions <= cfg_data[ActWidth-1:0];
      end
      for (int ch = 0; ch < MATCH_CHANNELS; ch++) begin
        if (cfg_index == CfgIndexWidth'(int'(CFG_MATCH_A) + ch)) begin
          match_value[ch] <= cfg_data;
        end
      end
    end
  end

  // Count value after one advance, and the match decode against it
  always_comb begin
    advanced_count = clear_pending ? '0 : count_value + 1'b1;
    set_flags = '0;
    do_clear  = 1'b0;
    do_stop   = 1'b0;
    for (int ch = 0; ch < MATCH_CHANNELS; ch++) begin
      hit[ch]       = (advanced_count == match_value[ch]);
      set_flags[ch] = hit[ch] && match_actions[ActionBits*ch + ActFlagBit];
      do_clear      = do_clear || (hit[ch] && match_actions[ActionBits*ch + ActClearBit]);
      do_stop       = do_stop  || (hit[ch] && match_actions[ActionBits*ch + ActStopBit]);
    end
  end

  // Next timer state and read data for the current item
  always_comb begin
    count_value_next    = count_value;
    prescale_count_next = prescale_count;
    enable_bit_next     = enable_bit;
    reset_hold_next     = reset_hold;
    flag_bits_next      = flag_bits;
    clear_pending_next  = clear_pending;
    rd                  = '0;
    case (mode)
      MODE_TICK: begin
        if (reset_hold) begin
          count_value_next    = '0;
          prescale_count_next = '0;
          clear_pending_next  = 1'b0;
        end else if (enable_bit) begin
          if (prescale_count >= prescale_limit) begin
            prescale_count_next = '0;
            count_value_next    = advanced_count;
            flag_bits_next      = flag_bits | set_flags;
            clear_pending_next  = do_clear;
            if (do_stop) begin
              enable_bit_next = 1'b0;
            end
          end else begin
            prescale_count_next = prescale_count + 1'b1;
          end
        end
      end
      MODE_WRITE: begin
        case (reg_select)
          SEL_FLAGS: begin
            flag_bits_next = flag_bits & ~write_data[MATCH_CHANNELS-1:0];
          end
          SEL_CONTROL: begin
            enable_bit_next = write_data[CtrlEnableBit];
            reset_hold_next = write_data[CtrlHoldBit];
            if (write_data[CtrlHoldBit]) begin
              count_value_next    = '0;
              prescale_count_next = '0;
              clear_pending_next  = 1'b0;
            end
          end
          SEL_COUNT:    count_value_next    = write_data;
          SEL_PRESCALE: prescale_count_next = write_data;
          default:      count_value_next    = count_value;
        endcase
      end
      MODE_READ: begin
        case (reg_select)
          SEL_FLAGS:    rd = DataWidth'(flag_bits);
          SEL_CONTROL:  rd = DataWidth'({reset_hold, enable_bit});
          SEL_COUNT:    rd = count_value;
          SEL_PRESCALE: rd = prescale_count;
          default:      rd = '0;
        endcase
      end
      default: rd = '0;
    endcase

    result_next.read_data = rd;
    result_next.irq       = |flag_bits_next;
    result_next.flags     = FlagWidth'(flag_bits_next);
    result_next.running   = enable_bit_next;
  end

  // Hold timer state; advance it on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      count_value    <= '0;
      prescale_count <= '0;
      enable_bit     <= 1'b0;
      reset_hold     <= 1'b0;
      flag_bits      <= '0;
      clear_pending  <= 1'b0;
    end else if (in_accept) begin
      count_value    <= count_value_next;
      prescale_count <= prescale_count_next;
      enable_bit     <= enable_bit_next;
      reset_hold     <= reset_hold_next;
      flag_bits      <= flag_bits_next;
      clear_pending  <= clear_pending_next;
    end
  end

  // Output register with a one-word skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_take || !out_valid) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_accept;
        end
      end else if (in_accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (in_accept) begin
        out_word <= result_next;
      end
    end else if (in_accept) begin
      skid_word <= result_next;
    end
  end

  assign read_data   = out_word.read_data;
  assign irq         = out_word.irq;
  assign match_flags = out_word.flags;
  assign running     = out_word.running;

`ifndef NO_ASSERTIONS
  // A word in the skid always has a word ahead of it
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid holds a word while the output register is empty");

  // The interrupt tracks the flags in every word shown
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (irq == (match_flags != '0)))
    else $error("irq disagrees with match_flags");

  // A tick under reset hold leaves both counters at zero
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && mode == MODE_TICK && reset_hold) |=>
      (count_value == '0 && prescale_count == '0 && !clear_pending))
    else $error("counters moved while held in reset");

  // The enable only drops on an accepted item
  assert property (@(posedge clk) disable iff (rst)
    $fell(enable_bit) |-> $past(in_accept))
    else $error("enable dropped without an item");

  // Nothing is accepted while the skid is full
  assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_stall) |=> $stable(count_value))
    else $error("timer state changed while stalled");
`endif

endmodule
